FILE: hdl/mal_pkg.sv
// Shared types, codes and field widths for the multi-ant Langton block.
package mal_pkg;

  localparam int CMD_W       = 2;
  localparam int COORD_W     = 8;
  localparam int IDX_W       = 4;
  localparam int HD_W        = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;
  localparam int NANT_CFG_W  = 4;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // commands on in_tuser
  localparam logic [CMD_W-1:0] CMD_STEP    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

  // result kinds on out_tuser
  localparam logic [CMD_W-1:0] KIND_ANT     = 2'd0;
  localparam logic [CMD_W-1:0] KIND_READ    = 2'd1;
  localparam logic [CMD_W-1:0] KIND_RESTART = 2'd2;

  // headings
  localparam logic [HD_W-1:0] HD_NORTH = 2'd0;
  localparam logic [HD_W-1:0] HD_EAST  = 2'd1;
  localparam logic [HD_W-1:0] HD_SOUTH = 2'd2;
  localparam logic [HD_W-1:0] HD_WEST  = 2'd3;
  localparam logic [HD_W-1:0] TURN_R   = 2'd1;
  localparam logic [HD_W-1:0] TURN_L   = 2'd3;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANTS        = 2'd2;
  localparam logic [CFG_DATA_W-1:0] RST_GRID_WIDTH  = 9'd144;
  localparam logic [CFG_DATA_W-1:0] RST_GRID_HEIGHT = 9'd168;
  localparam logic [NANT_CFG_W-1:0] RST_ANTS        = 4'd1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_FIX, ST_TURN_RD, ST_TURN_UPD, ST_TGL_RD, ST_TGL_WR,
    ST_MOVE, ST_EMIT, ST_READ_RD, ST_READ_RESP, ST_BDIV, ST_PLOAD, ST_PDIV,
    ST_RCLEAR, ST_RDONE
  } state_t;

  typedef struct packed {
    logic in_take;
    logic idx_clr;
    logic idx_inc;
    logic fix;
    logic rd_ant;
    logic turn;
    logic tgl_wr;
    logic move;
    logic emit_ant;
    logic rd_cell;
    logic emit_read;
    logic clr_wr;
    logic div_base;
    logic base_save;
    logic div_ant;
    logic place_save;
    logic emit_restart;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic idx_end;
    logic clr_last;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: hdl/mal_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mal_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/mal_ctrl.sv
// Controller state machine: sequences step, read and restart over the datapath.
module mal_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic [mal_pkg::CMD_W-1:0] in_tuser,
  output logic                      in_tready,
  input  mal_pkg::dp_sts_t          sts,
  output mal_pkg::dp_cmd_t          cmd
);

  mal_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mal_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mal_pkg::ST_CLEAR: if (sts.clr_last) state_nxt = mal_pkg::ST_IDLE;
      mal_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          priority if (in_tuser == mal_pkg::CMD_STEP) state_nxt = mal_pkg::ST_FIX;
          else if (in_tuser == mal_pkg::CMD_READ) state_nxt = mal_pkg::ST_READ_RD;
          else if (in_tuser == mal_pkg::CMD_RESTART) state_nxt = mal_pkg::ST_BDIV;
          else state_nxt = mal_pkg::ST_IDLE;
        end
      end
      mal_pkg::ST_FIX:      state_nxt = mal_pkg::ST_TURN_RD;
      mal_pkg::ST_TURN_RD:  state_nxt = mal_pkg::ST_TURN_UPD;
      mal_pkg::ST_TURN_UPD: state_nxt = sts.idx_last ? mal_pkg::ST_TGL_RD : mal_pkg::ST_TURN_RD;
      mal_pkg::ST_TGL_RD:   state_nxt = mal_pkg::ST_TGL_WR;
      mal_pkg::ST_TGL_WR:   state_nxt = sts.idx_last ? mal_pkg::ST_MOVE : mal_pkg::ST_TGL_RD;
      mal_pkg::ST_MOVE:     state_nxt = mal_pkg::ST_EMIT;
      mal_pkg::ST_EMIT:     if (sts.out_free && sts.idx_last) state_nxt = mal_pkg::ST_IDLE;
      mal_pkg::ST_READ_RD:  state_nxt = mal_pkg::ST_READ_RESP;
      mal_pkg::ST_READ_RESP: if (sts.out_free) state_nxt = mal_pkg::ST_IDLE;
      mal_pkg::ST_BDIV:     if (sts.div_done) state_nxt = mal_pkg::ST_PLOAD;
      mal_pkg::ST_PLOAD:    state_nxt = mal_pkg::ST_PDIV;
      mal_pkg::ST_PDIV: begin
        if (sts.div_done) begin
          state_nxt = sts.idx_end ? mal_pkg::ST_RCLEAR : mal_pkg::ST_PLOAD;
        end
      end
      mal_pkg::ST_RCLEAR:   if (sts.clr_last) state_nxt = mal_pkg::ST_RDONE;
      mal_pkg::ST_RDONE:    if (sts.out_free) state_nxt = mal_pkg::ST_IDLE;
      default:              state_nxt = mal_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      mal_pkg::ST_CLEAR, mal_pkg::ST_RCLEAR: cmd.clr_wr = 1'b1;
      mal_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.in_take  = 1'b1;
          cmd.idx_clr  = 1'b1;
          cmd.div_base = (in_tuser == mal_pkg::CMD_RESTART);
        end
      end
      mal_pkg::ST_FIX: cmd.fix = 1'b1;
      mal_pkg::ST_TURN_RD, mal_pkg::ST_TGL_RD: cmd.rd_ant = 1'b1;
      mal_pkg::ST_TURN_UPD: begin
        cmd.turn    = 1'b1;
        cmd.idx_clr = sts.idx_last;
        cmd.idx_inc = !sts.idx_last;
      end
      mal_pkg::ST_TGL_WR: begin
        cmd.tgl_wr  = 1'b1;
        cmd.idx_clr = sts.idx_last;
        cmd.idx_inc = !sts.idx_last;
      end
      mal_pkg::ST_MOVE: cmd.move = 1'b1;
      mal_pkg::ST_EMIT: begin
        cmd.emit_ant = sts.out_free;
        cmd.idx_inc  = sts.out_free && !sts.idx_last;
      end
      mal_pkg::ST_READ_RD:   cmd.rd_cell = 1'b1;
      mal_pkg::ST_READ_RESP: begin
        // keep the requested cell on the RAM address while the result waits
        cmd.rd_cell   = 1'b1;
        cmd.emit_read = sts.out_free;
      end
      mal_pkg::ST_BDIV: begin
        cmd.base_save = sts.div_done;
        cmd.idx_clr   = sts.div_done;
      end
      mal_pkg::ST_PLOAD: cmd.div_ant = 1'b1;
      mal_pkg::ST_PDIV: begin
        cmd.place_save = sts.div_done;
        cmd.idx_inc    = sts.div_done && !sts.idx_end;
      end
      mal_pkg::ST_RDONE: cmd.emit_restart = sts.out_free;
      default: ;
    endcase
  end

endmodule

FILE: hdl/mal_dp.sv
// Datapath: configuration, ant registers, grid RAM, placement divider, result register.
module mal_dp #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_ANTS   = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mal_pkg::dp_cmd_t                    cmd,
  output mal_pkg::dp_sts_t                    sts,
  input  logic [mal_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                cfg_we,
  input  logic [mal_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mal_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [mal_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [mal_pkg::CMD_W-1:0]           out_tuser,
  output logic                                out_tlast
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CW    = $clog2(MAX_ANTS + 1);
  localparam int IXW   = (MAX_ANTS > 1) ? $clog2(MAX_ANTS) : 1;

  // configuration
  logic [mal_pkg::CFG_DATA_W-1:0] gw_r, gh_r;
  logic [mal_pkg::NANT_CFG_W-1:0] nants_r;
  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic [CW-1:0] n;
  logic [XW-1:0] wm1;
  logic [YW-1:0] hm1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r    <= mal_pkg::RST_GRID_WIDTH;
      gh_r    <= mal_pkg::RST_GRID_HEIGHT;
      nants_r <= mal_pkg::RST_ANTS;
    end else if (cfg_we) begin
      if (cfg_index == mal_pkg::CFG_GRID_WIDTH)  gw_r <= cfg_data;
      if (cfg_index == mal_pkg::CFG_GRID_HEIGHT) gh_r <= cfg_data;
      if (cfg_index == mal_pkg::CFG_ANTS)        nants_r <= cfg_data[mal_pkg::NANT_CFG_W-1:0];
    end
  end

  // out-of-range settings clamp to 1..max
  always_comb begin
    if (gw_r == '0) w = WW'(1);
    else if (32'(gw_r) > MAX_WIDTH) w = WW'(MAX_WIDTH);
    else w = WW'(gw_r);
    if (gh_r == '0) h = HW'(1);
    else if (32'(gh_r) > MAX_HEIGHT) h = HW'(MAX_HEIGHT);
    else h = HW'(gh_r);
    if (nants_r == '0) n = CW'(1);
    else if (32'(nants_r) > MAX_ANTS) n = CW'(MAX_ANTS);
    else n = CW'(nants_r);
  end

  assign wm1 = XW'(w - WW'(1));
  assign hm1 = YW'(h - HW'(1));

  // ant index
  logic [IXW-1:0] idx_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + IXW'(1);
    end
  end

  logic idx_act;
  assign idx_act      = (CW'(idx_r) < n);
  assign sts.idx_last = ((CW'(idx_r) + CW'(1)) == n);
  assign sts.idx_end  = (32'(idx_r) == MAX_ANTS - 1);

  // latched read request
  logic [mal_pkg::COORD_W-1:0] rq_col_r, rq_row_r;
  logic                        rq_rng_r;
  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      rq_col_r <= in_tdata[mal_pkg::COORD_W-1:0];
      rq_row_r <= in_tdata[2*mal_pkg::COORD_W-1:mal_pkg::COORD_W];
    end
    if (cmd.rd_cell) begin
      rq_rng_r <= (WW'(rq_col_r) < w) && (HW'(rq_row_r) < h);
    end
  end

  // grid RAM
  logic [XW-1:0]   col_r [MAX_ANTS];
  logic [YW-1:0]   row_r [MAX_ANTS];
  logic [mal_pkg::HD_W-1:0] hd_r [MAX_ANTS];
  logic [AW-1:0]   ant_addr, cell_addr, clr_r;
  logic            ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0]   ram_waddr, ram_raddr;

  assign ant_addr  = AW'(AW'(row_r[idx_r]) * AW'(MAX_WIDTH)) + AW'(col_r[idx_r]);
  assign cell_addr = AW'(AW'(rq_row_r) * AW'(MAX_WIDTH)) + AW'(rq_col_r);
  assign ram_we    = cmd.clr_wr || cmd.tgl_wr;
  assign ram_waddr = cmd.clr_wr ? clr_r : ant_addr;
  assign ram_wdata = cmd.clr_wr ? 1'b0 : !ram_rdata;
  assign ram_raddr = cmd.rd_cell ? cell_addr : ant_addr;

  mal_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign sts.clr_last = (32'(clr_r) == DEPTH - 1);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_r <= sts.clr_last ? '0 : clr_r + AW'(1);
    end
  end

  // placement divider, repeated subtraction on both axes at once
  logic [WW+IXW-1:0] rem_c_r;
  logic [HW+IXW-1:0] rem_r_r;
  logic [CW:0]       dvs_r;
  logic [XW-1:0]     quo_c_r, base_c_r;
  logic [YW-1:0]     quo_r_r, base_r_r;
  logic              c_ge, r_ge;

  assign c_ge         = (rem_c_r >= (WW+IXW)'(dvs_r));
  assign r_ge         = (rem_r_r >= (HW+IXW)'(dvs_r));
  assign sts.div_done = !c_ge && !r_ge;

  always_ff @(posedge clk) begin
    if (cmd.div_base) begin
      rem_c_r <= (WW+IXW)'(w);
      rem_r_r <= (HW+IXW)'(h);
      dvs_r   <= {n, 1'b0};
      quo_c_r <= '0;
      quo_r_r <= '0;
    end else if (cmd.div_ant) begin
      rem_c_r <= (WW+IXW)'(w) * (WW+IXW)'(idx_r);
      rem_r_r <= (HW+IXW)'(h) * (HW+IXW)'(idx_r);
      dvs_r   <= (CW+1)'(n);
      quo_c_r <= '0;
      quo_r_r <= '0;
    end else begin
      if (c_ge) begin
        rem_c_r <= rem_c_r - (WW+IXW)'(dvs_r);
        quo_c_r <= quo_c_r + XW'(1);
      end
      if (r_ge) begin
        rem_r_r <= rem_r_r - (HW+IXW)'(dvs_r);
        quo_r_r <= quo_r_r + YW'(1);
      end
    end
    if (cmd.base_save) begin
      base_c_r <= quo_c_r;
      base_r_r <= quo_r_r;
    end
  end

  // move of every ant, one cell with wrap
  logic [XW-1:0] mv_col [MAX_ANTS];
  logic [YW-1:0] mv_row [MAX_ANTS];
  always_comb begin
    for (int i = 0; i < MAX_ANTS; i++) begin
      mv_col[i] = col_r[i];
      mv_row[i] = row_r[i];
      unique case (hd_r[i])
        mal_pkg::HD_NORTH: mv_row[i] = (row_r[i] >= hm1) ? '0 : row_r[i] + YW'(1);
        mal_pkg::HD_EAST:  mv_col[i] = (col_r[i] >= wm1) ? '0 : col_r[i] + XW'(1);
        mal_pkg::HD_SOUTH: mv_row[i] = (row_r[i] == '0) ? hm1 : row_r[i] - YW'(1);
        mal_pkg::HD_WEST:  mv_col[i] = (col_r[i] == '0) ? wm1 : col_r[i] - XW'(1);
        default: ;
      endcase
    end
  end

  // ant state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ANTS; i++) begin
        col_r[i] <= '0;
        row_r[i] <= '0;
        hd_r[i]  <= mal_pkg::HD_NORTH;
      end
    end else begin
      for (int i = 0; i < MAX_ANTS; i++) begin
        if (CW'(i) < n) begin
          if (cmd.fix && (col_r[i] > wm1)) col_r[i] <= '0;
          if (cmd.fix && (row_r[i] > hm1)) row_r[i] <= '0;
          if (cmd.move) begin
            col_r[i] <= mv_col[i];
            row_r[i] <= mv_row[i];
          end
        end
      end
      if (cmd.turn) begin
        hd_r[idx_r] <= hd_r[idx_r] + (ram_rdata ? mal_pkg::TURN_L : mal_pkg::TURN_R);
      end
      if (cmd.place_save) begin
        col_r[idx_r] <= idx_act ? base_c_r + quo_c_r : '0;
        row_r[idx_r] <= idx_act ? base_r_r + quo_r_r : '0;
        hd_r[idx_r]  <= mal_pkg::HD_NORTH;
      end
    end
  end

  // result register
  logic                              out_valid_r, out_last_r;
  logic [mal_pkg::OUT_TDATA_W-1:0]   out_data_r;
  logic [mal_pkg::CMD_W-1:0]         out_kind_r;
  logic                              load;

  assign load         = cmd.emit_ant || cmd.emit_read || cmd.emit_restart;
  assign sts.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.emit_ant) begin
      out_kind_r <= mal_pkg::KIND_ANT;
      out_last_r <= sts.idx_last;
      out_data_r <= {1'b0, 1'b0, hd_r[idx_r], mal_pkg::COORD_W'(row_r[idx_r]),
                     mal_pkg::COORD_W'(col_r[idx_r]), mal_pkg::IDX_W'(idx_r)};
    end else if (cmd.emit_read) begin
      out_kind_r <= mal_pkg::KIND_READ;
      out_last_r <= 1'b1;
      out_data_r <= {1'b0, ram_rdata & rq_rng_r, (mal_pkg::OUT_TDATA_W-2)'(0)};
    end else if (cmd.emit_restart) begin
      out_kind_r <= mal_pkg::KIND_RESTART;
      out_last_r <= 1'b1;
      out_data_r <= '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: hdl/multi_ant_langton_step.sv
// Multi-ant Langton's ant on a toroidal one-bit grid: top level.
// Step: per active ant a RAM read and a heading update to turn, then a read and a
//   write per ant to toggle, one move state for all ants, one result word per ant.
// Read: a RAM read, then the result word. Restart: placement divider over every ant slot, then a
//   clearing pass of all MAX_WIDTH*MAX_HEIGHT cells of the grid RAM, one cell a cycle.
// Reset: synchronous, active low; afterwards the same clearing pass runs before
//   the first word is taken; cfg writes taken always.
module multi_ant_langton_step #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_ANTS   = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // command channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mal_pkg::IN_TDATA_W-1:0]      in_tdata,  // [7:0] col, [15:8] row
  input  logic [mal_pkg::CMD_W-1:0]           in_tuser,  // [1:0] cmd
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mal_pkg::OUT_TDATA_W-1:0]     out_tdata, // [3:0] ant_index, [11:4] ant_col,
                                                         // [19:12] ant_row, [21:20] heading,
                                                         // [22] cell_black, [23] zero
  output logic [mal_pkg::CMD_W-1:0]           out_tuser, // [1:0] kind
  output logic                                out_tlast, // last word of this command
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mal_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mal_pkg::CFG_DATA_W-1:0]      cfg_data
);

  mal_pkg::dp_cmd_t cmd;
  mal_pkg::dp_sts_t sts;

  // registers may be written in any cycle; software only does so while idle
  assign cfg_ready = 1'b1;

  mal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tuser (in_tuser),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mal_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_ANTS  (MAX_ANTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

FILE: hdl/mal_chk.sv
// Port-level checker for the multi-ant Langton block, bound to the top level.
module mal_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [mal_pkg::CMD_W-1:0]       in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mal_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [mal_pkg::CMD_W-1:0]       out_tuser,
  input logic                            out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != mal_pkg::KIND_ANT |-> out_tlast)
    else $error("read or restart word without tlast");

  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == mal_pkg::KIND_READ |-> out_tdata[21:0] == '0)
    else $error("cell read carries ant fields");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser != mal_pkg::CMD_UNUSED |=> !in_tready)
    else $error("new word taken while a command is in progress");

endmodule

bind multi_ant_langton_step mal_chk u_chk (.*);

FILE: tb/tb_multi_ant_langton_step.sv
// Self-checking testbench for the multi-ant Langton step block.
module tb_multi_ant_langton_step;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GW = 256;
  localparam int GH = 256;
  localparam int NA = 10;
  localparam longint CYCLE_LIMIT = 20000000;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] col;
    logic [7:0] row;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] idx;
    logic [7:0] acol;
    logic [7:0] arow;
    logic [1:0] hd;
    logic       blk;
    logic       last;
  } res_word_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [mal_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic [mal_pkg::CMD_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [mal_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [mal_pkg::CMD_W-1:0] out_tuser;
  logic out_tlast;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [mal_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mal_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  multi_ant_langton_step dut (.*);

  // predictor state: grid, ants, registers
  bit        grid_q [GW*GH];
  bit [7:0]  ant_c [NA];
  bit [7:0]  ant_r [NA];
  bit [1:0]  ant_h [NA];
  int unsigned reg_w = 144, reg_h = 168, reg_n = 1;

  cmd_word_t pending_cmds[$];
  res_word_t expected_words[$];
  int  errors = 0;
  longint cycles = 0;
  int  words_seen = 0;
  bit  calm = 0;       // no idling on either side while set

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_multi_ant_langton_step: FAIL");
      $finish;
    end
  end

  function automatic int unsigned clampv(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // work out the result words for one accepted command
  task automatic predict_langton(cmd_word_t cw);
    int unsigned w, h, n, c, r, a;
    res_word_t rw;
    w = clampv(reg_w, GW);
    h = clampv(reg_h, GH);
    n = clampv(reg_n, NA);
    rw = '0;
    case (cw.cmd)
      mal_pkg::CMD_STEP: begin
        for (int i = 0; i < n; i++) begin
          if (ant_c[i] >= w) ant_c[i] = 0;
          if (ant_r[i] >= h) ant_r[i] = 0;
        end
        for (int i = 0; i < n; i++)
          ant_h[i] = ant_h[i] + (grid_q[ant_r[i]*GW+ant_c[i]] ? mal_pkg::TURN_L
                                                             : mal_pkg::TURN_R);
        for (int i = 0; i < n; i++) begin
          a = ant_r[i]*GW + ant_c[i];
          grid_q[a] = ~grid_q[a];
        end
        for (int i = 0; i < n; i++) begin
          c = ant_c[i];
          r = ant_r[i];
          case (ant_h[i])
            mal_pkg::HD_NORTH: r = (r + 1 >= h) ? 0 : r + 1;
            mal_pkg::HD_EAST:  c = (c + 1 >= w) ? 0 : c + 1;
            mal_pkg::HD_SOUTH: r = (r == 0) ? h - 1 : r - 1;
            default:           c = (c == 0) ? w - 1 : c - 1;
          endcase
          ant_c[i] = 8'(c);
          ant_r[i] = 8'(r);
        end
        for (int i = 0; i < n; i++) begin
          rw = '0;
          rw.kind = mal_pkg::KIND_ANT;
          rw.idx = 4'(i);
          rw.acol = ant_c[i];
          rw.arow = ant_r[i];
          rw.hd = ant_h[i];
          rw.last = (i + 1 == n);
          expected_words.push_back(rw);
        end
      end
      mal_pkg::CMD_READ: begin
        rw.kind = mal_pkg::KIND_READ;
        rw.last = 1;
        if (cw.col < w && cw.row < h) rw.blk = grid_q[cw.row*GW + cw.col];
        expected_words.push_back(rw);
      end
      mal_pkg::CMD_RESTART: begin
        foreach (grid_q[k]) grid_q[k] = 0;
        for (int i = 0; i < NA; i++) begin
          if (i < n) begin
            ant_c[i] = 8'(w / (n*2) + (w*i) / n);
            ant_r[i] = 8'(h / (n*2) + (h*i) / n);
          end else begin
            ant_c[i] = 0;
            ant_r[i] = 0;
          end
          ant_h[i] = mal_pkg::HD_NORTH;
        end
        rw.kind = mal_pkg::KIND_RESTART;
        rw.last = 1;
        expected_words.push_back(rw);
      end
      default: ;  // unused command: nothing comes back
    endcase
  endtask

  task automatic report_mismatch(string what);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // driver: one word from the queue, random idle gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_langton({in_tuser, in_tdata[7:0], in_tdata[15:8]});
      if (!in_tvalid || in_tready) begin
        if (pending_cmds.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
          cmd_word_t cw;
          cw = pending_cmds.pop_front();
          in_tvalid <= 1;
          in_tuser <= cw.cmd;
          in_tdata <= {cw.row, cw.col};
        end else
          in_tvalid <= 0;
      end
    end
  end

  // monitor: compare each word with the oldest expectation, random stalls
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        res_word_t got, exp_w;
        got = {out_tuser, out_tdata[3:0], out_tdata[11:4], out_tdata[19:12],
               out_tdata[21:20], out_tdata[22], out_tlast};
        words_seen <= words_seen + 1;
        if (expected_words.size() == 0)
          report_mismatch($sformatf("unexpected word %h", got));
        else begin
          exp_w = expected_words.pop_front();
          if (got.kind != exp_w.kind)
            report_mismatch($sformatf("kind %0d want %0d", got.kind, exp_w.kind));
          if (got.idx != exp_w.idx)
            report_mismatch($sformatf("ant %0d want %0d", got.idx, exp_w.idx));
          if (got.acol != exp_w.acol)
            report_mismatch($sformatf("ant %0d col %0d want %0d",
                                      exp_w.idx, got.acol, exp_w.acol));
          if (got.arow != exp_w.arow)
            report_mismatch($sformatf("ant %0d row %0d want %0d",
                                      exp_w.idx, got.arow, exp_w.arow));
          if (got.hd != exp_w.hd)
            report_mismatch($sformatf("ant %0d heading %0d want %0d",
                                      exp_w.idx, got.hd, exp_w.hd));
          if (got.blk != exp_w.blk)
            report_mismatch($sformatf("cell %0d want %0d", got.blk, exp_w.blk));
          if (got.last != exp_w.last)
            report_mismatch($sformatf("last %0d want %0d", got.last, exp_w.last));
        end
      end
      out_tready <= calm || ($urandom_range(99) >= 13);
    end
  end

  // sampled on the falling edge so the driver's updates have settled
  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_tvalid || expected_words.size() > 0)
      @(negedge clk);
    repeat (80) @(posedge clk);  // unused command leaves nothing to wait for
  endtask

  task automatic write_reg(logic [mal_pkg::CFG_IDX_W-1:0] ix, int unsigned v);
    cfg_valid <= 1;
    cfg_index <= ix;
    cfg_data <= mal_pkg::CFG_DATA_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (ix)
      mal_pkg::CFG_GRID_WIDTH:  reg_w = v & 9'h1ff;
      mal_pkg::CFG_GRID_HEIGHT: reg_h = v & 9'h1ff;
      default:                  reg_n = v & 4'hf;
    endcase
  endtask

  task automatic queue_cmd(logic [1:0] c, logic [7:0] col = 0, logic [7:0] row = 0);
    cmd_word_t cw;
    cw.cmd = c;
    cw.col = col;
    cw.row = row;
    pending_cmds.push_back(cw);
  endtask

  // random phase: mostly steps, reads scattered over the whole field range
  task automatic random_burst(int count);
    for (int k = 0; k < count; k++) begin
      int unsigned p;
      p = $urandom_range(99);
      if (p < 60) queue_cmd(mal_pkg::CMD_STEP, 8'($urandom), 8'($urandom));
      else if (p < 90) queue_cmd(mal_pkg::CMD_READ, 8'($urandom), 8'($urandom));
      else if (p < 93) queue_cmd(mal_pkg::CMD_RESTART);
      else queue_cmd(mal_pkg::CMD_UNUSED, 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    // phase 1: default size, one ant, directed corners and every command
    queue_cmd(mal_pkg::CMD_STEP);
    queue_cmd(mal_pkg::CMD_READ, 0, 0);
    queue_cmd(mal_pkg::CMD_READ, 8'hff, 8'hff);
    queue_cmd(mal_pkg::CMD_READ, 143, 167);
    queue_cmd(mal_pkg::CMD_UNUSED, 8'haa, 8'h55);
    queue_cmd(mal_pkg::CMD_RESTART);
    queue_cmd(mal_pkg::CMD_STEP, 8'hff, 8'hff);
    queue_cmd(mal_pkg::CMD_STEP);
    queue_cmd(mal_pkg::CMD_READ, 72, 84);
    wait_drained();
    // ants raised without restart, then a shrink leaves ants outside
    write_reg(mal_pkg::CFG_ANTS, 10);
    queue_cmd(mal_pkg::CMD_STEP);
    queue_cmd(mal_pkg::CMD_STEP);
    wait_drained();
    write_reg(mal_pkg::CFG_GRID_WIDTH, 4);
    write_reg(mal_pkg::CFG_GRID_HEIGHT, 3);
    queue_cmd(mal_pkg::CMD_STEP);
    queue_cmd(mal_pkg::CMD_READ, 3, 2);
    queue_cmd(mal_pkg::CMD_READ, 4, 0);
    wait_drained();
    // out-of-range registers: zero sizes, ant count above the maximum
    write_reg(mal_pkg::CFG_GRID_WIDTH, 0);
    write_reg(mal_pkg::CFG_GRID_HEIGHT, 0);
    write_reg(mal_pkg::CFG_ANTS, 15);
    queue_cmd(mal_pkg::CMD_RESTART);
    queue_cmd(mal_pkg::CMD_STEP);
    queue_cmd(mal_pkg::CMD_READ, 0, 0);
    wait_drained();
    write_reg(mal_pkg::CFG_GRID_WIDTH, 511);
    write_reg(mal_pkg::CFG_GRID_HEIGHT, 300);
    write_reg(mal_pkg::CFG_ANTS, 0);
    queue_cmd(mal_pkg::CMD_RESTART);
    queue_cmd(mal_pkg::CMD_STEP);
    queue_cmd(mal_pkg::CMD_READ, 255, 255);
    wait_drained();
    // random phases over several settings; the middle one runs without idling
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(mal_pkg::CFG_GRID_WIDTH, (ph == 4) ? 256 : $urandom_range(1, 12));
      write_reg(mal_pkg::CFG_GRID_HEIGHT, (ph == 4) ? 1 : $urandom_range(1, 12));
      write_reg(mal_pkg::CFG_ANTS, (ph == 0) ? 1 : $urandom_range(0, 15));
      calm = (ph == 2);
      queue_cmd(mal_pkg::CMD_RESTART);
      random_burst(69);
      wait_drained();
    end
    calm = 0;
    repeat (200) @(posedge clk);
    $display("covered %0d result words over sizes from 1x1 to 256x256 and 1..10 ants",
             words_seen);
    $display("steps, reads inside and outside the area, restarts and unused commands");
    if (errors == 0) $display("tb_multi_ant_langton_step: PASS");
    else $display("tb_multi_ant_langton_step: FAIL");
    $finish;
  end
endmodule

FILE: filelist.f
hdl/mal_pkg.sv
hdl/mal_ram.sv
hdl/mal_ctrl.sv
hdl/mal_dp.sv
hdl/multi_ant_langton_step.sv
hdl/mal_chk.sv
tb/tb_multi_ant_langton_step.sv
